// ===== sv/hrksg_pkg.sv =====
// Package with the constants and tables of the hashed random key string generator.
package hrksg_pkg;

    localparam int unsigned HRK_MAX_BYTES = 512;
    localparam int unsigned LEN_W         = 10;
    localparam int unsigned NUM_W         = 7;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c13;

    localparam logic [7:0] CHUNK_5 = 8'd248;
    localparam logic [7:0] CHUNK_4 = 8'd120;
    localparam logic [7:0] CHUNK_3 = 8'd56;
    localparam logic [7:0] CHUNK_2 = 8'd24;
    localparam logic [7:0] CHUNK_1 = 8'd8;

    // Roles of the mix lines: which of a, b, c is updated.
    typedef enum logic [1:0] {
        ROLE_A = 2'd0,
        ROLE_B = 2'd1,
        ROLE_C = 2'd2
    } t_role;

    // Subsets of five randoms, ordered by size and then lexicographically.
    function automatic logic [4:0] f_subset(input logic [4:0] idx);
        logic [4:0] s;
        unique case (idx)
            5'd0:  s = 5'h01;
            5'd1:  s = 5'h02;
            5'd2:  s = 5'h04;
            5'd3:  s = 5'h08;
            5'd4:  s = 5'h10;
            5'd5:  s = 5'h03;
            5'd6:  s = 5'h05;
            5'd7:  s = 5'h09;
            5'd8:  s = 5'h11;
            5'd9:  s = 5'h06;
            5'd10: s = 5'h0A;
            5'd11: s = 5'h12;
            5'd12: s = 5'h0C;
            5'd13: s = 5'h14;
            5'd14: s = 5'h18;
            5'd15: s = 5'h07;
            5'd16: s = 5'h0B;
            5'd17: s = 5'h13;
            5'd18: s = 5'h0D;
            5'd19: s = 5'h15;
            5'd20: s = 5'h19;
            5'd21: s = 5'h0E;
            5'd22: s = 5'h16;
            5'd23: s = 5'h1A;
            5'd24: s = 5'h1C;
            5'd25: s = 5'h0F;
            5'd26: s = 5'h17;
            5'd27: s = 5'h1B;
            5'd28: s = 5'h1D;
            5'd29: s = 5'h1E;
            default: s = 5'h1F;
        endcase
        return s;
    endfunction

    // Shift amount of each of the twelve mix lines.
    function automatic logic [5:0] f_shift(input logic [3:0] step);
        logic [5:0] amt;
        unique case (step)
            4'd0:  amt = 6'd43;
            4'd1:  amt = 6'd9;
            4'd2:  amt = 6'd8;
            4'd3:  amt = 6'd38;
            4'd4:  amt = 6'd23;
            4'd5:  amt = 6'd5;
            4'd6:  amt = 6'd35;
            4'd7:  amt = 6'd49;
            4'd8:  amt = 6'd11;
            4'd9:  amt = 6'd12;
            4'd10: amt = 6'd18;
            default: amt = 6'd22;
        endcase
        return amt;
    endfunction

    function automatic logic [63:0] f_mask(input logic [1:0] sel);
        logic [63:0] m;
        unique case (sel)
            2'd0: m = 64'h3f3f3f3f3f3f3f3f;
            2'd1: m = 64'h4f4f4f4f4f4f4f4f;
            2'd2: m = 64'h5f5f5f5f5f5f5f5f;
            default: m = 64'h6f6f6f6f6f6f6f6f;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] f_set(input logic [1:0] sel);
        logic [63:0] v;
        unique case (sel)
            2'd0: v = 64'h3030303030303030;
            2'd1: v = 64'h4040404040404040;
            2'd2: v = 64'h5050505050505050;
            default: v = 64'h6060606060606060;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/hashed_random_key_string_gen_core.sv =====
// Top level of the hashed random key string generator.
//
// An item on the input channel (i_in_valid / o_in_ready) carries a seed and
// a byte length; the block answers with the key string as a series of
// 64-bit words on the output channel (o_out_valid / i_out_ready), first
// string byte in bits 7:0, o_byte_count valid bytes, o_last on the final
// word. A length of zero gives no words; lengths above MAX_BYTES saturate.
// The block takes one item at a time and drops o_in_ready until its last
// word has been loaded into the output register.
// Timing is set by one shared mix unit that does one mix line per cycle:
// each random takes one load and twelve lines. A chunk then takes one pick
// state, a load and twelve lines per random, and a scan of the subset
// slots (31 for five randoms, 26 for four, 16 for three, 6 for two, 1 for
// one). A stall on the output holds the sequencer at the word that waits
// to be sent.
// Reset clears the sequencer and the output valid; no clearing pass runs.
module hashed_random_key_string_gen_core
    import hrksg_pkg::*;
#(
    parameter int unsigned MAX_BYTES = HRK_MAX_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [63:0]       i_seed,
    input  logic [LEN_W-1:0]  i_byte_length,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [63:0]       o_word,
    output logic [3:0]        o_byte_count,
    output logic              o_last
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_LOAD,
        S_HASH,
        S_EMIT,
        S_TAIL
    } t_state;

    t_state           r_state;
    logic [63:0]      r_seed;
    logic [1:0]       r_sel;
    logic [LEN_W-1:0] r_len;
    logic [NUM_W-1:0] r_n;
    logic [2:0]       r_k;
    logic [7:0]       r_chunk;
    logic             r_tail;
    logic [2:0]       r_ridx;
    logic [4:0]       r_i;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_c;
    logic [3:0]       r_step;
    t_role            r_role;
    logic [63:0]      r_rd [5];
    logic             r_out_valid;
    logic [63:0]      r_word;
    logic [3:0]       r_byte_count;
    logic             r_last;

    // Shared mix unit: one line x -= y; x -= z; x ^= (z shifted) per cycle.
    logic [63:0] mix_x;
    logic [63:0] mix_y;
    logic [63:0] mix_z;
    logic [63:0] mix_sh;
    logic [63:0] mix_out;
    logic [5:0]  mix_amt;

    always_comb begin
        mix_amt = f_shift(r_step);
        unique case (r_role)
            ROLE_A: begin
                mix_x = r_a;
                mix_y = r_b;
                mix_z = r_c;
            end
            ROLE_B: begin
                mix_x = r_b;
                mix_y = r_c;
                mix_z = r_a;
            end
            default: begin
                mix_x = r_c;
                mix_y = r_a;
                mix_z = r_b;
            end
        endcase
        mix_sh  = (r_role == ROLE_B) ? (mix_z << mix_amt) : (mix_z >> mix_amt);
        mix_out = (mix_x - mix_y - mix_z) ^ mix_sh;
    end

    // Subset selection for chunk output.
    logic [4:0]  sub;
    logic [5:0]  sub_lim;
    logic        sub_ok;
    logic        sub_full;
    logic [63:0] sub_xor;
    logic [63:0] pat_mask;
    logic [63:0] pat_set;
    logic [63:0] tail_keep;
    logic        out_free;
    logic [LEN_W-1:0] len_left;
    logic [LEN_W-1:0] len_sat;

    always_comb begin
        sub      = f_subset(r_i);
        sub_lim  = 6'd1 << r_k;
        sub_ok   = {1'b0, sub} < sub_lim;
        sub_full = ({1'b0, sub} == (sub_lim - 6'd1));
        sub_xor  = '0;
        for (int j = 0; j < 5; j++) begin
            if (sub[j]) begin
                sub_xor = sub_xor ^ r_rd[j];
            end
        end
        pat_mask  = f_mask(r_sel);
        pat_set   = f_set(r_sel);
        tail_keep = ~(64'hFFFF_FFFF_FFFF_FFFF << {r_len[2:0], 3'b000});
        out_free  = !r_out_valid || i_out_ready;
        len_left  = r_len - LEN_W'(r_chunk);
        len_sat   = (i_byte_length > MaxLen) ? MaxLen : i_byte_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_seed <= i_seed;
                        r_sel  <= i_seed[5:4];
                        r_len  <= len_sat;
                        r_n    <= '0;
                        if (len_sat != '0) begin
                            r_state <= S_PICK;
                        end
                    end
                end
                S_PICK: begin
                    r_ridx <= '0;
                    r_i    <= '0;
                    r_tail <= 1'b0;
                    r_state <= S_LOAD;
                    priority if (r_len >= LEN_W'(CHUNK_5)) begin
                        r_k     <= 3'd5;
                        r_chunk <= CHUNK_5;
                    end else if (r_len >= LEN_W'(CHUNK_4)) begin
                        r_k     <= 3'd4;
                        r_chunk <= CHUNK_4;
                    end else if (r_len >= LEN_W'(CHUNK_3)) begin
                        r_k     <= 3'd3;
                        r_chunk <= CHUNK_3;
                    end else if (r_len >= LEN_W'(CHUNK_2)) begin
                        r_k     <= 3'd2;
                        r_chunk <= CHUNK_2;
                    end else if (r_len >= LEN_W'(CHUNK_1)) begin
                        r_k     <= 3'd1;
                        r_chunk <= CHUNK_1;
                    end else begin
                        r_k     <= 3'd1;
                        r_chunk <= '0;
                        r_tail  <= 1'b1;
                    end
                end
                S_LOAD: begin
                    r_a     <= r_seed + 64'(r_n);
                    r_b     <= 64'(r_n);
                    r_c     <= GOLDEN;
                    r_step  <= '0;
                    r_role  <= ROLE_A;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    unique case (r_role)
                        ROLE_A:  r_a <= mix_out;
                        ROLE_B:  r_b <= mix_out;
                        default: r_c <= mix_out;
                    endcase
                    unique case (r_role)
                        ROLE_A:  r_role <= ROLE_B;
                        ROLE_B:  r_role <= ROLE_C;
                        default: r_role <= ROLE_A;
                    endcase
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd11) begin
                        r_rd[r_ridx] <= mix_out;
                        r_n          <= r_n + NUM_W'(1);
                        if ({1'b0, r_ridx} + 4'd1 < {1'b0, r_k}) begin
                            r_ridx  <= r_ridx + 3'd1;
                            r_state <= S_LOAD;
                        end else if (r_tail) begin
                            r_state <= S_TAIL;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (!sub_ok) begin
                        r_i <= r_i + 5'd1;
                    end else if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_word       <= (sub_xor & pat_mask) | pat_set;
                        r_byte_count <= 4'd8;
                        r_last       <= sub_full && (len_left == '0);
                        if (sub_full) begin
                            r_len   <= len_left;
                            r_state <= (len_left == '0) ? S_IDLE : S_PICK;
                        end else begin
                            r_i <= r_i + 5'd1;
                        end
                    end
                end
                S_TAIL: begin
                    // The tail random gives only its low len bytes.
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_word       <= ((r_rd[0] & pat_mask) | pat_set) & tail_keep;
                        r_byte_count <= {1'b0, r_len[2:0]};
                        r_last       <= 1'b1;
                        r_len        <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_word       = r_word;
    assign o_byte_count = r_byte_count;
    assign o_last       = r_last;

endmodule

// ===== verif/hashed_random_key_string_gen_core_tb.sv =====
// Self-checking testbench of the hashed random key string generator core.
module hashed_random_key_string_gen_core_tb
    import hrksg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MIX_INIT_C  = 64'h9e3779b97f4a7c13;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 300;
    localparam int          QUIET_LIMIT = 4000;

    // Subsets of up to five randoms (bit i = random i of the chunk), by size and then
    // lexicographically on the random indexes.
    localparam logic [4:0] SUBSET_ORDER [31] = '{
        5'h01, 5'h02, 5'h04, 5'h08, 5'h10,
        5'h03, 5'h05, 5'h09, 5'h11, 5'h06, 5'h0A, 5'h12, 5'h0C, 5'h14, 5'h18,
        5'h07, 5'h0B, 5'h13, 5'h0D, 5'h15, 5'h19, 5'h0E, 5'h16, 5'h1A, 5'h1C,
        5'h0F, 5'h17, 5'h1B, 5'h1D, 5'h1E,
        5'h1F
    };

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  byte_count;
        logic        last;
    } key_word_t;

    class key_string_tracker;
        key_word_t expected_words[$];
        int        mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function logic [63:0] mix64(input logic [63:0] seed, input logic [63:0] n);
            logic [63:0] a, b, c;
            a = seed + n;
            b = n;
            c = MIX_INIT_C;
            a = a - b - c; a = a ^ (c >> 43);
            b = b - c - a; b = b ^ (a << 9);
            c = c - a - b; c = c ^ (b >> 8);
            a = a - b - c; a = a ^ (c >> 38);
            b = b - c - a; b = b ^ (a << 23);
            c = c - a - b; c = c ^ (b >> 5);
            a = a - b - c; a = a ^ (c >> 35);
            b = b - c - a; b = b ^ (a << 49);
            c = c - a - b; c = c ^ (b >> 11);
            a = a - b - c; a = a ^ (c >> 12);
            b = b - c - a; b = b ^ (a << 18);
            c = c - a - b; c = c ^ (b >> 22);
            return c;
        endfunction

        // Works out every word of the string for one accepted request.
        function void note_request(input logic [63:0] seed, input logic [LEN_W-1:0] len_in);
            key_word_t   words[$];
            logic [63:0] rands[5];
            logic [63:0] v, keep, msk, setv, n;
            logic [3:0]  hi;
            int unsigned remaining, k, i, j;
            hi = 4'd3 + {2'b00, seed[5:4]};
            msk = {8{hi, 4'hf}};
            setv = {8{hi, 4'h0}};
            remaining = (len_in > HRK_MAX_BYTES) ? HRK_MAX_BYTES : len_in;
            n = 64'd0;
            while (remaining > 0 && words.size() < 64) begin
                if (remaining >= 8) begin
                    // A chunk of k randoms covers 2^k - 1 words.
                    k = 5;
                    while (8 * ((1 << k) - 1) > remaining)
                        k--;
                    for (i = 0; i < k; i++) begin
                        rands[i] = mix64(seed, n);
                        n++;
                    end
                    for (i = 0; i < 31 && words.size() < 64; i++) begin
                        if (SUBSET_ORDER[i] < (1 << k)) begin
                            v = 64'd0;
                            for (j = 0; j < k; j++)
                                if (SUBSET_ORDER[i][j])
                                    v = v ^ rands[j];
                            words.push_back(key_word_t'{(v & msk) | setv, 4'd8, 1'b0});
                        end
                    end
                    remaining -= 8 * ((1 << k) - 1);
                end else begin
                    v = (mix64(seed, n) & msk) | setv;
                    n++;
                    keep = (64'd1 << (8 * remaining)) - 64'd1;
                    words.push_back(key_word_t'{v & keep, 4'(remaining), 1'b0});
                    remaining = 0;
                end
            end
            if (words.size() > 0)
                words[words.size() - 1].last = 1'b1;
            foreach (words[w])
                expected_words.push_back(words[w]);
        endfunction

        task report_mismatch(input string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_word(input logic [63:0] word, input logic [3:0] cnt, input logic last);
            key_word_t want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h count %0d last %0b",
                    word, cnt, last));
            end else begin
                want = expected_words.pop_front();
                if (word !== want.word || cnt !== want.byte_count || last !== want.last)
                    report_mismatch($sformatf(
                        "word %h count %0d last %0b, expected %h count %0d last %0b",
                        word, cnt, last, want.word, want.byte_count, want.last));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [63:0]      i_seed = 64'd0;
    logic [LEN_W-1:0] i_byte_length = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [63:0]      o_word;
    logic [3:0]       o_byte_count;
    logic             o_last;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;

    key_string_tracker tracker = new();

    hashed_random_key_string_gen_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_seed        (i_seed),
        .i_byte_length (i_byte_length),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word        (o_word),
        .o_byte_count  (o_byte_count),
        .o_last        (o_last)
    );

    always #1 i_clk = ~i_clk;

    task automatic send_request(input logic [63:0] seed, input logic [LEN_W-1:0] len);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_seed <= seed;
        i_byte_length <= len;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        tracker.note_request(seed, len);
    endtask

    task automatic send_random_requests(input int count, input int min_len);
        logic [63:0]      seed;
        logic [LEN_W-1:0] len;
        int unsigned      pick;
        repeat (count) begin
            seed = {$urandom, $urandom};
            pick = $urandom_range(99, 0);
            // Mostly short strings keep the run fast; the rest reach the long chunks.
            if (pick < 60)
                len = LEN_W'($urandom_range(64, 0));
            else if (pick < 85)
                len = LEN_W'($urandom_range(260, 65));
            else if (pick < 95)
                len = LEN_W'($urandom_range(512, 261));
            else
                len = LEN_W'($urandom_range(1023, 513));
            if (len < min_len)
                len = LEN_W'(min_len);
            send_request(seed, len);
        end
    endtask

    // Output side: checks every accepted word and decides the next ready.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                tracker.check_word(o_word, o_byte_count, o_last);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int          lengths[21];
        logic [63:0] seed;
        int          i;
        lengths = '{0, 1, 7, 8, 9, 23, 24, 25, 55, 56, 57, 119, 120, 121,
                    247, 248, 249, 511, 512, 513, 1023};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every chunk boundary, saturation, the seed extremes, all mask pairs.
        for (i = 0; i < 21; i++) begin
            if (i == 0)
                seed = 64'd0;
            else if (i == 1)
                seed = '1;
            else begin
                seed = {$urandom, $urandom};
                seed[5:4] = 2'(i);
            end
            send_request(seed, LEN_W'(lengths[i]));
        end
        send_request(64'hFFFF_FFFF_FFFF_FFCF, LEN_W'(0));
        send_random_requests(65, 0);

        send_idle_pct = 78;
        send_random_requests(65, 0);

        send_idle_pct = 0;
        recv_stall_pct = 78;
        send_random_requests(65, 0);

        send_idle_pct = 34;
        recv_stall_pct = 34;
        send_random_requests(65, 0);

        // Output held off while requests keep coming, so the input side backs up.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        send_random_requests(20, 100);

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
